// File: rtl/dgom_pkg.sv
// ----------------------------------------------------------------------------
// dgom_pkg
// Shared widths, register indexes and pipeline token for the grid offset map.
// ----------------------------------------------------------------------------
package dgom_pkg;

  localparam int COUNT_BITS   = 12;
  localparam int CW           = COUNT_BITS + 1;    // clamped count width
  localparam int IDX_W        = 36;
  localparam int REG_W        = 13;
  localparam int MQ_W         = 2 * COUNT_BITS;    // mapped dividend width
  // product of two lower grid counts, up to 2^(2*COUNT_BITS) inclusive
  localparam int STRIDE_W     = 2 * COUNT_BITS + 1;
  localparam int MAX_DIMS_DEF = 3;
  localparam int IX_W         = 3;

  typedef enum logic [IX_W-1:0] {
    REG_DIMS  = 3'd0,
    REG_DATA0 = 3'd1,
    REG_DATA1 = 3'd2,
    REG_DATA2 = 3'd3,
    REG_GRID0 = 3'd4,
    REG_GRID1 = 3'd5,
    REG_GRID2 = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    CELL_MAIN,     // one bit of index / data count
    CELL_MAPSET,   // coordinate times (grid count - 1)
    CELL_MAP,      // one bit of scaled coordinate / (data count - 1)
    CELL_ACC,      // add mapped coordinate times stride
    CELL_STRIDE    // stride times grid count
  } cell_kind_t;

  typedef struct packed {
    logic [IDX_W-1:0]    rest;
    logic [CW-1:0]       rem;
    logic [MQ_W-1:0]     mq;
    logic [CW-1:0]       mrem;
    logic [IDX_W-1:0]    offset;
    logic [STRIDE_W-1:0] stride;
  } token_t;

endpackage

// File: rtl/data_to_grid_offset_map_core.sv
// ----------------------------------------------------------------------------
// data_to_grid_offset_map_core
// Maps a linear data-point index to a linear grid offset.
// ----------------------------------------------------------------------------
// Accepts one index per cycle and returns one result per index, in order.
// The dimension chains run in series, followed by the output register; each dimension
// is a chain of 63 cells, 36 restoring-division steps that split off the
// coordinate, one multiply, 24 division steps that scale it to the grid, and
// one multiply-add and one stride multiply. The whole chain advances together
// and stalls only when the output register holds an untaken result.
// Out of range is detected as a nonzero index left after the last dimension.
module data_to_grid_offset_map_core #(
  parameter int MAX_DIMS = dgom_pkg::MAX_DIMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dgom_pkg::IDX_W-1:0]    point_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dgom_pkg::IDX_W-1:0]    grid_offset,
  output logic                          out_of_range,
  input  logic                          wr_en,
  input  logic [dgom_pkg::IX_W-1:0]     wr_index,
  input  logic [dgom_pkg::REG_W-1:0]    wr_data
);
  import dgom_pkg::*;

  logic [1:0]       dims_in_use;
  logic [REG_W-1:0] data_points [3];
  logic [REG_W-1:0] grid_points [3];
  logic [1:0]       k_used;
  logic             advance;

  logic          vld [MAX_DIMS+1];
  token_t        tok [MAX_DIMS+1];
  logic [CW-1:0] dcl [MAX_DIMS];
  logic [CW-1:0] gcl [MAX_DIMS];

  function automatic logic [CW-1:0] clamp_count(input logic [REG_W-1:0] v);
    logic [31:0] v32;
    logic [31:0] top;
    v32 = 32'(v);
    top = 32'(1) << COUNT_BITS;
    if (v32 == 32'd0) return CW'(1);
    if (v32 > top) return CW'(top);
    return CW'(v32);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= 2'd1;
      for (int d = 0; d < 3; d++) begin
        data_points[d] <= REG_W'(1);
        grid_points[d] <= REG_W'(1);
      end
    end else if (wr_en) begin
      case (wr_index)
        REG_DIMS:  dims_in_use    <= wr_data[1:0];
        REG_DATA0: data_points[0] <= wr_data;
        REG_DATA1: data_points[1] <= wr_data;
        REG_DATA2: data_points[2] <= wr_data;
        REG_GRID0: grid_points[0] <= wr_data;
        REG_GRID1: grid_points[1] <= wr_data;
        REG_GRID2: grid_points[2] <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dims_in_use == 2'd0) k_used = 2'd1;
    else if (32'(dims_in_use) > MAX_DIMS) k_used = 2'(MAX_DIMS);
    else k_used = dims_in_use;
  end

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  assign vld[0]        = in_valid;
  assign tok[0].rest   = point_index;
  assign tok[0].rem    = '0;
  assign tok[0].mq     = '0;
  assign tok[0].mrem   = '0;
  assign tok[0].offset = '0;
  assign tok[0].stride = STRIDE_W'(1);

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
    // unused dimensions act as size one
    assign dcl[d] = (d < 32'(k_used)) ? clamp_count(data_points[d]) : CW'(1);
    assign gcl[d] = (d < 32'(k_used)) ? clamp_count(grid_points[d]) : CW'(1);
    dgom_dim u_dim (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .in_valid  (vld[d]),
      .in_tok    (tok[d]),
      .dc        (dcl[d]),
      .gc        (gcl[d]),
      .out_valid (vld[d+1]),
      .out_tok   (tok[d+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= vld[MAX_DIMS];
    end
    if (advance) begin
      out_of_range <= (tok[MAX_DIMS].rest != '0);
      grid_offset  <= (tok[MAX_DIMS].rest != '0) ? '0 : tok[MAX_DIMS].offset;
    end
  end

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> grid_offset == '0)
    else $error("out-of-range result carries nonzero offset");

  a_one_dim_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range && k_used == 2'd1
      |-> grid_offset[IDX_W-1:COUNT_BITS] == '0)
    else $error("single-dimension offset beyond grid count");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

endmodule

// File: rtl/dgom_cell.sv
// ----------------------------------------------------------------------------
// dgom_cell
// One pipeline cell: a single division step, a single multiply step or a multiply-add.
// ----------------------------------------------------------------------------
module dgom_cell #(
  parameter dgom_pkg::cell_kind_t KIND = dgom_pkg::CELL_MAIN
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  dgom_pkg::token_t          in_tok,
  input  logic [dgom_pkg::CW-1:0]   dc,
  input  logic [dgom_pkg::CW-1:0]   gc,
  output logic                      out_valid,
  output dgom_pkg::token_t          out_tok
);
  import dgom_pkg::*;

  token_t                tok_next;
  logic [CW-1:0]         t;
  logic [CW-1:0]         md;
  logic [COUNT_BITS-1:0] gm1;

  always_comb begin
    tok_next = in_tok;
    t        = '0;
    md       = '0;
    gm1      = '0;
    case (KIND)
      CELL_MAIN: begin
        t = {in_tok.rem[COUNT_BITS-1:0], in_tok.rest[IDX_W-1]};
        if (t >= dc) begin
          tok_next.rem  = t - dc;
          tok_next.rest = {in_tok.rest[IDX_W-2:0], 1'b1};
        end else begin
          tok_next.rem  = t;
          tok_next.rest = {in_tok.rest[IDX_W-2:0], 1'b0};
        end
      end
      CELL_MAPSET: begin
        gm1          = COUNT_BITS'(gc - CW'(1));
        tok_next.mq  = MQ_W'(in_tok.rem[COUNT_BITS-1:0] * gm1);
        tok_next.mrem = '0;
        tok_next.rem  = '0;
      end
      CELL_MAP: begin
        // a single data point gives coordinate 0; divide by 1 keeps it 0
        md = (dc > CW'(1)) ? (dc - CW'(1)) : CW'(1);
        t  = {in_tok.mrem[COUNT_BITS-1:0], in_tok.mq[MQ_W-1]};
        if (t >= md) begin
          tok_next.mrem = t - md;
          tok_next.mq   = {in_tok.mq[MQ_W-2:0], 1'b1};
        end else begin
          tok_next.mrem = t;
          tok_next.mq   = {in_tok.mq[MQ_W-2:0], 1'b0};
        end
      end
      CELL_ACC: begin
        tok_next.offset = in_tok.offset
                        + IDX_W'(in_tok.mq[COUNT_BITS-1:0] * in_tok.stride);
      end
      CELL_STRIDE: begin
        tok_next.stride = STRIDE_W'(in_tok.stride * gc);
      end
      default: begin
        tok_next = in_tok;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_tok <= tok_next;
    end
  end

endmodule

// File: rtl/dgom_dim.sv
// ----------------------------------------------------------------------------
// dgom_dim
// Cell chain for one dimension: split off the coordinate, scale it, weight it.
// ----------------------------------------------------------------------------
module dgom_dim (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  dgom_pkg::token_t          in_tok,
  input  logic [dgom_pkg::CW-1:0]   dc,
  input  logic [dgom_pkg::CW-1:0]   gc,
  output logic                      out_valid,
  output dgom_pkg::token_t          out_tok
);
  import dgom_pkg::*;

  localparam int NCELL = IDX_W + 1 + MQ_W + 2;

  logic   vld [NCELL+1];
  token_t tok [NCELL+1];

  assign vld[0] = in_valid;
  assign tok[0] = in_tok;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    localparam cell_kind_t K =
      (i < IDX_W)            ? CELL_MAIN   :
      (i == IDX_W)           ? CELL_MAPSET :
      (i < IDX_W + 1 + MQ_W) ? CELL_MAP    :
      (i == IDX_W + 1 + MQ_W) ? CELL_ACC   : CELL_STRIDE;
    dgom_cell #(.KIND(K)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vld[i]),
      .in_tok    (tok[i]),
      .dc        (dc),
      .gc        (gc),
      .out_valid (vld[i+1]),
      .out_tok   (tok[i+1])
    );
  end

  assign out_valid = vld[NCELL];
  assign out_tok   = tok[NCELL];

endmodule
